// ----- sv/pcmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmc_pkg
// shared widths, constants and types of the point chase motion command block
// ----------------------------------------------------------------------------
package pcmc_pkg;

    // position width and derived datapath widths
    localparam int POS_BITS = 16;
    localparam int DIST_W   = POS_BITS + 1;
    localparam int SUM_W    = 2 * POS_BITS + 1;
    localparam int RAD_W    = 2 * DIST_W;
    localparam int REM_W    = DIST_W + 3;
    localparam bit HAS_OVF  = (SUM_W > 64);

    // fixed field widths
    localparam int GH_W    = 16;
    localparam int PH_W    = 15;
    localparam int GAIN_W  = 12;
    localparam int LIM_W   = 10;
    localparam int REACH_W = 16;
    localparam int FWD_W   = 10;
    localparam int TURN_W  = 11;
    localparam int MAG_W   = 14;
    localparam int SCALE_W = 9;

    // heading path widths
    localparam int HPROD_W   = 34;
    localparam int GDEG_W    = 18;
    localparam int ERR_RAW_W = 18;

    // gain path widths
    localparam int P1_W        = DIST_W + GAIN_W;
    localparam int P2_W        = P1_W + SCALE_W;
    localparam int FWD_SHIFT   = 16;
    localparam int FR_W        = P2_W - FWD_SHIFT;
    localparam int TP_W        = MAG_W + GAIN_W;
    localparam int TURN_SHIFT  = 14;
    localparam int TRN_RAW_W   = TP_W - TURN_SHIFT;
    localparam int CMP_W       = (DIST_W > REACH_W) ? DIST_W : REACH_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP_DISTANCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_HEADING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_DISTANCE = 3'd4;

    localparam logic [GAIN_W-1:0]  RST_KP_DISTANCE    = 12'd384;
    localparam logic [GAIN_W-1:0]  RST_KP_HEADING     = 12'd256;
    localparam logic [LIM_W-1:0]   RST_MAX_FORWARD    = 10'd300;
    localparam logic [LIM_W-1:0]   RST_MAX_TURN       = 10'd120;
    localparam logic [REACH_W-1:0] RST_REACH_DISTANCE = 16'd8;

    // radians q3.12 to degrees*64, factor in q16
    localparam logic signed [HPROD_W-1:0] DEG_FACTOR = 34'sd58671;
    localparam logic signed [HPROD_W-1:0] DEG_HALF   = 34'sd32768;

    // heading wrap bounds in degrees*64
    localparam logic signed [ERR_RAW_W-1:0] WRAP_HALF       = 18'sd11520;
    localparam logic signed [ERR_RAW_W-1:0] WRAP_FULL       = 18'sd23040;
    localparam logic signed [ERR_RAW_W-1:0] WRAP_THREE_HALF = 18'sd34560;
    localparam logic signed [ERR_RAW_W-1:0] WRAP_TWO        = 18'sd46080;

    // forward scale steps, q.8; thresholds in degrees*64
    localparam logic [MAG_W-1:0]   THR_STOP  = 14'd7680;
    localparam logic [MAG_W-1:0]   THR_SLOW  = 14'd5760;
    localparam logic [MAG_W-1:0]   THR_HALF  = 14'd2880;
    localparam logic [SCALE_W-1:0] SCALE_STOP = 9'd0;
    localparam logic [SCALE_W-1:0] SCALE_SLOW = 9'd38;
    localparam logic [SCALE_W-1:0] SCALE_HALF = 9'd115;
    localparam logic [SCALE_W-1:0] SCALE_FULL = 9'd256;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(64'hFFFF_FFFF);

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_distance;
        logic [GAIN_W-1:0]  kp_heading;
        logic [LIM_W-1:0]   max_forward;
        logic [LIM_W-1:0]   max_turn;
        logic [REACH_W-1:0] reach_distance;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             ovf;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
        t_side             side;
    } t_cell;

endpackage

// ----- sv/pcmc_in_if.sv -----
// ----------------------------------------------------------------------------
// pcmc_in_if
// goal and pose word channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcmc_in_if import pcmc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] goal_x;
    logic signed [POS_BITS-1:0] goal_y;
    logic signed [GH_W-1:0]     goal_heading;
    logic signed [POS_BITS-1:0] pose_x;
    logic signed [POS_BITS-1:0] pose_y;
    logic signed [PH_W-1:0]     pose_heading;

    modport source (
        output valid, goal_x, goal_y, goal_heading, pose_x, pose_y, pose_heading,
        input  ready
    );
    modport sink (
        input  valid, goal_x, goal_y, goal_heading, pose_x, pose_y, pose_heading,
        output ready
    );
endinterface

// ----- sv/pcmc_out_if.sv -----
// ----------------------------------------------------------------------------
// pcmc_out_if
// motion command word channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcmc_out_if import pcmc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FWD_W-1:0]         speed;
    logic signed [TURN_W-1:0] steer;
    logic                     reached;

    modport source (
        output valid, speed, steer, reached,
        input  ready
    );
    modport sink (
        input  valid, speed, steer, reached,
        output ready
    );
endinterface

// ----- sv/pcmc_front.sv -----
// ----------------------------------------------------------------------------
// pcmc_front
// squared distance and wrapped heading error, three pipeline stages
// ----------------------------------------------------------------------------
module pcmc_front import pcmc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [POS_BITS-1:0] i_goal_x,
    input  logic signed [POS_BITS-1:0] i_goal_y,
    input  logic signed [GH_W-1:0]     i_goal_heading,
    input  logic signed [POS_BITS-1:0] i_pose_x,
    input  logic signed [POS_BITS-1:0] i_pose_y,
    input  logic signed [PH_W-1:0]     i_pose_heading,
    output logic                       o_valid,
    output t_cell                      o_cell
);

    // stage 1: absolute differences, heading product
    logic signed [POS_BITS:0]    dx, dy;
    logic [POS_BITS-1:0]         n1_ax, n1_ay;
    logic signed [HPROD_W-1:0]   gh_ext, n1_hprod;
    logic                        r1_valid;
    logic [POS_BITS-1:0]         r1_ax, r1_ay;
    logic signed [HPROD_W-1:0]   r1_hprod;
    logic signed [PH_W-1:0]      r1_ph;

    assign dx = $signed({i_goal_x[POS_BITS-1], i_goal_x})
              - $signed({i_pose_x[POS_BITS-1], i_pose_x});
    assign dy = $signed({i_goal_y[POS_BITS-1], i_goal_y})
              - $signed({i_pose_y[POS_BITS-1], i_pose_y});
    assign gh_ext = HPROD_W'(i_goal_heading);

    always_comb begin
        n1_ax    = dx[POS_BITS] ? POS_BITS'(-dx) : dx[POS_BITS-1:0];
        n1_ay    = dy[POS_BITS] ? POS_BITS'(-dy) : dy[POS_BITS-1:0];
        n1_hprod = gh_ext * DEG_FACTOR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_ax    <= n1_ax;
            r1_ay    <= n1_ay;
            r1_hprod <= n1_hprod;
            r1_ph    <= i_pose_heading;
        end
    end

    // stage 2: squares, raw heading error
    logic [2*POS_BITS-1:0]        ax_w, ay_w, n2_sx, n2_sy;
    logic signed [HPROD_W-1:0]    hround, hshift;
    logic signed [GDEG_W-1:0]     gdeg;
    logic signed [ERR_RAW_W-1:0]  n2_err;
    logic                         r2_valid;
    logic [2*POS_BITS-1:0]        r2_sx, r2_sy;
    logic signed [ERR_RAW_W-1:0]  r2_err;

    always_comb begin
        ax_w   = {{POS_BITS{1'b0}}, r1_ax};
        ay_w   = {{POS_BITS{1'b0}}, r1_ay};
        n2_sx  = ax_w * ax_w;
        n2_sy  = ay_w * ay_w;
        hround = r1_hprod + DEG_HALF;
        hshift = hround >>> 16;
        gdeg   = hshift[GDEG_W-1:0];
        n2_err = ERR_RAW_W'(gdeg) - ERR_RAW_W'(r1_ph);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_sx  <= n2_sx;
            r2_sy  <= n2_sy;
            r2_err <= n2_err;
        end
    end

    // stage 3: sum of squares, wrapped error, magnitude
    logic [SUM_W-1:0]            sum;
    logic signed [ERR_RAW_W-1:0] ewrap, eabs;
    logic                        r3_valid;
    t_cell                       n3_cell, r3_cell;

    always_comb begin
        sum = SUM_W'(r2_sx) + SUM_W'(r2_sy);
        if (r2_err > WRAP_THREE_HALF) begin
            ewrap = r2_err - WRAP_TWO;
        end else if (r2_err > WRAP_HALF) begin
            ewrap = r2_err - WRAP_FULL;
        end else if (r2_err < -WRAP_THREE_HALF) begin
            ewrap = r2_err + WRAP_TWO;
        end else if (r2_err < -WRAP_HALF) begin
            ewrap = r2_err + WRAP_FULL;
        end else begin
            ewrap = r2_err;
        end
        eabs              = ewrap[ERR_RAW_W-1] ? -ewrap : ewrap;
        n3_cell.rad       = RAD_W'(sum);
        n3_cell.rem       = '0;
        n3_cell.root      = '0;
        n3_cell.side.mag  = eabs[MAG_W-1:0];
        n3_cell.side.neg  = ewrap[ERR_RAW_W-1];
        n3_cell.side.ovf  = HAS_OVF && sum[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_cell <= n3_cell;
        end
    end

    assign o_valid = r3_valid;
    assign o_cell  = r3_cell;

endmodule

// ----- sv/pcmc_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// pcmc_sqrt_cell
// one digit of the integer square root, registered toward its neighbor
// ----------------------------------------------------------------------------
module pcmc_sqrt_cell import pcmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic [REM_W-1:0] rem_sh, trial;
    logic             take;
    t_cell            n_cell, r_cell;
    logic             r_valid;

    always_comb begin
        rem_sh      = {i_cell.rem[REM_W-3:0], i_cell.rad[RAD_W-1 -: 2]};
        trial       = REM_W'({i_cell.root, 2'b01});
        take        = (rem_sh >= trial);
        n_cell.rad  = {i_cell.rad[RAD_W-3:0], 2'b00};
        n_cell.rem  = take ? (rem_sh - trial) : rem_sh;
        n_cell.root = {i_cell.root[DIST_W-2:0], take};
        n_cell.side = i_cell.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// ----- sv/pcmc_back.sv -----
// ----------------------------------------------------------------------------
// pcmc_back
// gains, forward scale, saturation and the output word register
// ----------------------------------------------------------------------------
module pcmc_back import pcmc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_cell                    i_cell,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic [FWD_W-1:0]         o_speed,
    output logic signed [TURN_W-1:0] o_steer,
    output logic                     o_reached
);

    // stage 1: distance and heading products, forward scale step, reach compare
    logic [DIST_W-1:0]  root_dist;
    logic [P1_W-1:0]    n1_p1;
    logic [TP_W-1:0]    n1_tp;
    logic [SCALE_W-1:0] n1_scale;
    logic               n1_reached;
    logic               r1_valid, r1_neg, r1_reached;
    logic [P1_W-1:0]    r1_p1;
    logic [TP_W-1:0]    r1_tp;
    logic [SCALE_W-1:0] r1_scale;

    always_comb begin
        root_dist = i_cell.side.ovf ? DIST_MAX : i_cell.root;
        n1_p1     = P1_W'(root_dist) * P1_W'(i_cfg.kp_distance);
        n1_tp     = TP_W'(i_cell.side.mag) * TP_W'(i_cfg.kp_heading);
        if (i_cell.side.mag > THR_STOP) begin
            n1_scale = SCALE_STOP;
        end else if (i_cell.side.mag > THR_SLOW) begin
            n1_scale = SCALE_SLOW;
        end else if (i_cell.side.mag > THR_HALF) begin
            n1_scale = SCALE_HALF;
        end else begin
            n1_scale = SCALE_FULL;
        end
        n1_reached = (CMP_W'(root_dist) <= CMP_W'(i_cfg.reach_distance));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_p1      <= n1_p1;
            r1_tp      <= n1_tp;
            r1_scale   <= n1_scale;
            r1_neg     <= i_cell.side.neg;
            r1_reached <= n1_reached;
        end
    end

    // stage 2: forward scale product, turn clamp
    logic [P2_W-1:0]      n2_p2;
    logic [TRN_RAW_W-1:0] trn_raw;
    logic [LIM_W-1:0]     n2_trn;
    logic                 r2_valid, r2_neg, r2_reached;
    logic [P2_W-1:0]      r2_p2;
    logic [LIM_W-1:0]     r2_trn;

    always_comb begin
        n2_p2   = P2_W'(r1_p1) * P2_W'(r1_scale);
        trn_raw = r1_tp[TP_W-1:TURN_SHIFT];
        n2_trn  = (trn_raw > TRN_RAW_W'(i_cfg.max_turn)) ? i_cfg.max_turn
                                                         : trn_raw[LIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_p2      <= n2_p2;
            r2_trn     <= n2_trn;
            r2_neg     <= r1_neg;
            r2_reached <= r1_reached;
        end
    end

    // stage 3: forward clamp, turn sign, output word
    logic [FR_W-1:0]          fwd_raw;
    logic [FWD_W-1:0]         n_fwd;
    logic signed [TURN_W-1:0] trn_ext, n_turn;
    logic                     r_valid, r_reached;
    logic [FWD_W-1:0]         r_fwd;
    logic signed [TURN_W-1:0] r_turn;

    always_comb begin
        fwd_raw = r2_p2[P2_W-1:FWD_SHIFT];
        n_fwd   = (fwd_raw > FR_W'(i_cfg.max_forward)) ? i_cfg.max_forward
                                                       : fwd_raw[FWD_W-1:0];
        trn_ext = TURN_W'(r2_trn);
        n_turn  = r2_neg ? -trn_ext : trn_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r2_valid;
        end
        if (i_en) begin
            r_fwd     <= n_fwd;
            r_turn    <= n_turn;
            r_reached <= r2_reached;
        end
    end

    assign o_valid   = r_valid;
    assign o_speed   = r_fwd;
    assign o_steer   = r_turn;
    assign o_reached = r_reached;

endmodule

// ----- sv/point_chase_motion_command.sv -----
// ----------------------------------------------------------------------------
// point_chase_motion_command
// proportional go-to-point controller: distance by a chain of square root
// cells, heading error wrap, gains, forward scale and saturation
// ----------------------------------------------------------------------------
//  channel   dir   handshake         word
//  i_goal    in    valid / ready     goal x, y, heading and pose x, y, heading
//  o_motion  out   valid / ready     speed, steer, reached
//  i_cfg_*   in    write enable      register index and data, no read-back
//
//  one word per cycle unless the output word is held; the pipeline holds
//  three front stages, one square root cell per distance bit, three back stages
//  synchronous active-low reset clears the stage valid bits and loads the config defaults
//  a held output word freezes the whole pipeline; i_goal.ready drops with it
// ----------------------------------------------------------------------------
module point_chase_motion_command import pcmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcmc_in_if.sink               i_goal,
    pcmc_out_if.source            o_motion,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  en;
    logic  out_valid;
    logic  chain_valid [DIST_W+1];
    t_cell chain_cell  [DIST_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_distance    <= RST_KP_DISTANCE;
            r_cfg.kp_heading     <= RST_KP_HEADING;
            r_cfg.max_forward    <= RST_MAX_FORWARD;
            r_cfg.max_turn       <= RST_MAX_TURN;
            r_cfg.reach_distance <= RST_REACH_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KP_DISTANCE:    r_cfg.kp_distance    <= i_cfg_data[GAIN_W-1:0];
                REG_KP_HEADING:     r_cfg.kp_heading     <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_FORWARD:    r_cfg.max_forward    <= i_cfg_data[LIM_W-1:0];
                REG_MAX_TURN:       r_cfg.max_turn       <= i_cfg_data[LIM_W-1:0];
                REG_REACH_DISTANCE: r_cfg.reach_distance <= i_cfg_data[REACH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign en           = !out_valid || o_motion.ready;
    assign i_goal.ready = en;

    pcmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_goal.valid),
        .i_goal_x       (i_goal.goal_x),
        .i_goal_y       (i_goal.goal_y),
        .i_goal_heading (i_goal.goal_heading),
        .i_pose_x       (i_goal.pose_x),
        .i_pose_y       (i_goal.pose_y),
        .i_pose_heading (i_goal.pose_heading),
        .o_valid        (chain_valid[0]),
        .o_cell         (chain_cell[0])
    );

    for (genvar g = 0; g < DIST_W; g++) begin : g_sqrt
        pcmc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_cell  (chain_cell[g]),
            .o_valid (chain_valid[g+1]),
            .o_cell  (chain_cell[g+1])
        );
    end

    pcmc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (chain_valid[DIST_W]),
        .i_cell    (chain_cell[DIST_W]),
        .i_cfg     (r_cfg),
        .o_valid   (out_valid),
        .o_speed   (o_motion.speed),
        .o_steer   (o_motion.steer),
        .o_reached (o_motion.reached)
    );

    assign o_motion.valid = out_valid;

endmodule
